// File: hdl/spa_pkg.sv
// Shared types and constants for the sparse polynomial adder.
// No dependencies.
`timescale 1ns / 1ps

package spa_pkg;

    localparam int SPA_MAX_TERMS = 32;
    localparam int COEF_W        = 16;
    localparam int EXPON_W       = 16;
    localparam int SUM_W         = COEF_W + 1;
    localparam int WORD_W        = COEF_W + EXPON_W;

    typedef enum logic [1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_ADD         = 2'd2
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

endpackage

// File: hdl/sparse_polynomial_add.sv
// A load writes one term; an add walks both term stores, one merge step per cycle unless
// out_stall holds the output register and a new result is ready. Loads are taken one per cycle
// while idle; an add holds in_stall until the merge is done and the output register is free.
// Results leave through one output register after a one-term lookahead (for is_last).
// Reset: counts, overflow flag and control clear; term memories are not cleared.
// Depends on spa_pkg.
`timescale 1ns / 1ps

module sparse_polynomial_add
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = SPA_MAX_TERMS
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                cmd,
    input  logic signed [COEF_W-1:0]  coef,
    input  logic [EXPON_W-1:0]        expon,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [SUM_W-1:0]   sum_coef,
    output logic [EXPON_W-1:0]        sum_expon,
    output logic                      is_last,
    output logic                      is_empty,
    output logic                      overflowed
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

    // term memories
    logic [WORD_W-1:0] first_mem  [MAX_TERMS];
    logic [WORD_W-1:0] second_mem [MAX_TERMS];
    logic [WORD_W-1:0] first_rd_reg;
    logic [WORD_W-1:0] second_rd_reg;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] first_count_reg, first_count_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic             ovf_reg, ovf_next;

    logic                     pend_valid_reg, pend_valid_next;
    logic signed [SUM_W-1:0]  pend_coef_reg, pend_coef_next;
    logic [EXPON_W-1:0]       pend_expon_reg, pend_expon_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]  out_coef_reg, out_coef_next;
    logic [EXPON_W-1:0]       out_expon_reg, out_expon_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_empty_reg, out_empty_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic                     in_take;
    logic                     start;
    logic                     we_first;
    logic                     we_second;
    logic [WORD_W-1:0]        wr_word;
    logic                     a_ok;
    logic                     b_ok;
    logic                     merge_done;
    logic                     out_free;
    logic                     step;
    logic                     finish;
    logic                     take_a;
    logic                     take_b;
    logic                     cand_valid;
    logic signed [SUM_W-1:0]  cand_coef;
    logic [EXPON_W-1:0]       cand_expon;
    logic signed [COEF_W-1:0] ca;
    logic signed [COEF_W-1:0] cb;
    logic [EXPON_W-1:0]       ea;
    logic [EXPON_W-1:0]       eb;
    logic signed [SUM_W-1:0]  pair_sum;

    // ---------------------------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------------------------
    assign in_take = in_valid && !in_stall;
    assign wr_word = {expon, coef};

    always_comb
    begin
        start     = 1'b0;
        we_first  = 1'b0;
        we_second = 1'b0;
        ovf_next  = ovf_reg;
        if (in_take)
        begin
            case (cmd)
                CMD_LOAD_FIRST:
                begin
                    if (first_count_reg < CNT_MAX)
                        we_first = 1'b1;
                    else
                        ovf_next = 1'b1;
                end
                CMD_LOAD_SECOND:
                begin
                    if (second_count_reg < CNT_MAX)
                        we_second = 1'b1;
                    else
                        ovf_next = 1'b1;
                end
                CMD_ADD:
                begin
                    start = 1'b1;
                end
                default:
                begin
                    start = 1'b0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------------------------
    // Merge step on the current head terms
    // ---------------------------------------------------------------------------------------
    assign ca       = first_rd_reg[COEF_W-1:0];
    assign ea       = first_rd_reg[WORD_W-1:COEF_W];
    assign cb       = second_rd_reg[COEF_W-1:0];
    assign eb       = second_rd_reg[WORD_W-1:COEF_W];
    assign pair_sum = SUM_W'(ca) + SUM_W'(cb);

    assign a_ok       = a_reg < first_count_reg;
    assign b_ok       = b_reg < second_count_reg;
    assign merge_done = !a_ok && !b_ok;
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        take_a     = 1'b0;
        take_b     = 1'b0;
        cand_valid = 1'b0;
        cand_coef  = '0;
        cand_expon = '0;
        if (a_ok && b_ok)
        begin
            if (ea == eb)
            begin
                take_a     = 1'b1;
                take_b     = 1'b1;
                cand_valid = (pair_sum != '0);
                cand_coef  = pair_sum;
                cand_expon = ea;
            end
            else if (ea > eb)
            begin
                take_a     = 1'b1;
                cand_valid = 1'b1;
                cand_coef  = SUM_W'(ca);
                cand_expon = ea;
            end
            else
            begin
                take_b     = 1'b1;
                cand_valid = 1'b1;
                cand_coef  = SUM_W'(cb);
                cand_expon = eb;
            end
        end
        else if (a_ok)
        begin
            take_a     = 1'b1;
            cand_valid = 1'b1;
            cand_coef  = SUM_W'(ca);
            cand_expon = ea;
        end
        else if (b_ok)
        begin
            take_b     = 1'b1;
            cand_valid = 1'b1;
            cand_coef  = SUM_W'(cb);
            cand_expon = eb;
        end
    end

    // hold the heads while a new result waits on a full, stalled output register
    assign step   = (state_reg == ST_MERGE) && !merge_done
                    && !(cand_valid && pend_valid_reg && !out_free);
    assign finish = (state_reg == ST_MERGE) && merge_done && out_free;

    // ---------------------------------------------------------------------------------------
    // Next values
    // ---------------------------------------------------------------------------------------
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (start)
        begin
            a_next = '0;
            b_next = '0;
        end
        else if (step)
        begin
            if (take_a)
                a_next = a_reg + 1'b1;
            if (take_b)
                b_next = b_reg + 1'b1;
        end
    end

    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        if (finish)
        begin
            first_count_next  = '0;
            second_count_next = '0;
        end
        else
        begin
            if (we_first)
                first_count_next = first_count_reg + 1'b1;
            if (we_second)
                second_count_next = second_count_reg + 1'b1;
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_coef_next  = pend_coef_reg;
        pend_expon_next = pend_expon_reg;
        if (finish)
        begin
            pend_valid_next = 1'b0;
        end
        else if (step && cand_valid)
        begin
            pend_valid_next = 1'b1;
            pend_coef_next  = cand_coef;
            pend_expon_next = cand_expon;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_coef_next  = out_coef_reg;
        out_expon_next = out_expon_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            out_ovf_next   = ovf_reg;
            if (pend_valid_reg)
            begin
                out_coef_next  = pend_coef_reg;
                out_expon_next = pend_expon_reg;
                out_empty_next = 1'b0;
            end
            else
            begin
                out_coef_next  = '0;
                out_expon_next = '0;
                out_empty_next = 1'b1;
            end
        end
        else if (step && cand_valid && pend_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_coef_next  = pend_coef_reg;
            out_expon_next = pend_expon_reg;
            out_last_next  = 1'b0;
            out_empty_next = 1'b0;
            out_ovf_next   = ovf_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_MERGE: in_stall = 1'b1;
            default:  in_stall = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            a_reg            <= '0;
            b_reg            <= '0;
            ovf_reg          <= 1'b0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            a_reg            <= a_next;
            b_reg            <= b_next;
            ovf_reg          <= ovf_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_coef_reg  <= pend_coef_next;
        pend_expon_reg <= pend_expon_next;
        out_coef_reg   <= out_coef_next;
        out_expon_reg  <= out_expon_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
        out_ovf_reg    <= out_ovf_next;
    end

    // read at the next head so data lines up with a_reg and b_reg
    always_ff @(posedge clk)
    begin
        if (we_first)
            first_mem[first_count_reg[IDX_W-1:0]] <= wr_word;
        first_rd_reg <= first_mem[a_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (we_second)
            second_mem[second_count_reg[IDX_W-1:0]] <= wr_word;
        second_rd_reg <= second_mem[b_next[IDX_W-1:0]];
    end

    assign out_valid  = out_valid_reg;
    assign sum_coef   = out_coef_reg;
    assign sum_expon  = out_expon_reg;
    assign is_last    = out_last_reg;
    assign is_empty   = out_empty_reg;
    assign overflowed = out_ovf_reg;

    // ---------------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------------
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left behind after merge");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= CNT_MAX) && (second_count_reg <= CNT_MAX))
        else $error("term count beyond capacity");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> (is_last && sum_coef == '0 && sum_expon == '0))
        else $error("empty result not well formed");

    a_stores_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (first_count_reg == '0 && second_count_reg == '0 && state_reg == ST_IDLE))
        else $error("stores not emptied after add");

endmodule
